>>> hw/rtl/sfy_pkg.sv
// Shared constants, types and helpers for the seeded shuffle block.
package sfy_pkg;

	localparam logic [63:0] SALT   = 64'hA11CE5571CECAFEF;
	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

	localparam int SHR1 = 30;
	localparam int SHR2 = 27;
	localparam int SHR3 = 31;

	localparam int RND_W  = 64;
	localparam int DIG_W  = 4;
	localparam int DIG_N  = RND_W / DIG_W;
	localparam int DIG_CW = $clog2(DIG_N);

	localparam int MOD_STEP  = 2;
	localparam int MOD_CNT_N = RND_W / MOD_STEP;
	localparam int MOD_CW    = $clog2(MOD_CNT_N);

	localparam int POS_W = 6;

	typedef struct packed {
		logic seed_load;
		logic start;
	} gen_ctl_t;

	function automatic logic [DIG_W-1:0] const_digit(input logic [RND_W-1:0] c,
			input logic [DIG_CW-1:0] idx);
		const_digit = c[idx*DIG_W +: DIG_W];
	endfunction

endpackage

>>> hw/rtl/sfy_gen.sv
// Splitmix64 generator with digit-serial constant multiplies.
module sfy_gen (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sfy_pkg::gen_ctl_t       ctl,
	input  logic [sfy_pkg::RND_W-1:0] seed,
	output logic                    done,
	output logic [sfy_pkg::RND_W-1:0] rnd
);
	import sfy_pkg::*;

	typedef enum logic [4:0] {
		G_IDLE = 5'b00001,
		G_MUL1 = 5'b00010,
		G_MIX  = 5'b00100,
		G_MUL2 = 5'b01000,
		G_FIN  = 5'b10000
	} gen_st_t;

	gen_st_t             st_q;
	logic [RND_W-1:0]    state_q;
	logic [RND_W-1:0]    mcand_q;
	logic [RND_W-1:0]    acc_q;
	logic [RND_W-1:0]    rnd_q;
	logic [DIG_CW-1:0]   cnt_q;
	logic                done_q;

	logic [RND_W-1:0]    state_add;
	logic [DIG_CW-1:0]   didx;
	logic [DIG_W-1:0]    dig;
	logic [RND_W-1:0]    prod;
	logic [RND_W-1:0]    acc_nxt;

	always_comb begin
		state_add = state_q + GOLDEN;
		didx      = DIG_CW'(DIG_N - 1) - cnt_q;
		dig       = const_digit((st_q == G_MUL1) ? MIX1 : MIX2, didx);
		prod      = '0;
		for (int b = 0; b < DIG_W; b++) begin
			if (dig[b]) begin
				prod = prod + (mcand_q << b);
			end
		end
		acc_nxt = (acc_q << DIG_W) + prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= G_IDLE;
			state_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.seed_load) begin
				state_q <= seed ^ SALT;
			end
			unique case (st_q)
				G_IDLE: begin
					if (ctl.start) begin
						state_q <= state_add;
						cnt_q   <= '0;
						st_q    <= G_MUL1;
					end
				end
				G_MUL1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIG_CW'(DIG_N - 1)) begin
						st_q <= G_MIX;
					end
				end
				G_MIX: begin
					cnt_q <= '0;
					st_q  <= G_MUL2;
				end
				G_MUL2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIG_CW'(DIG_N - 1)) begin
						st_q <= G_FIN;
					end
				end
				G_FIN: begin
					done_q <= 1'b1;
					st_q   <= G_IDLE;
				end
				default: begin
					st_q <= G_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			G_IDLE: begin
				mcand_q <= state_add ^ (state_add >> SHR1);
				acc_q   <= '0;
			end
			G_MUL1, G_MUL2: begin
				acc_q <= acc_nxt;
			end
			G_MIX: begin
				mcand_q <= acc_q ^ (acc_q >> SHR2);
				acc_q   <= '0;
			end
			G_FIN: begin
				rnd_q <= acc_q ^ (acc_q >> SHR3);
			end
			default: begin
				acc_q <= '0;
			end
		endcase
	end

	assign done = done_q;
	assign rnd  = rnd_q;

endmodule

>>> hw/rtl/sfy_mod.sv
// Serial remainder unit, two dividend bits per cycle.
module sfy_mod #(
	parameter int DW = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sfy_pkg::RND_W-1:0] dividend,
	input  logic [DW-1:0]             divisor,
	output logic                      done,
	output logic [DW-1:0]             rem
);
	import sfy_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [MOD_CW-1:0] cnt_q;
	logic [RND_W-1:0]  sh_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     rem_nxt;

	always_comb begin
		logic [DW:0] t;
		rem_nxt = rem_q;
		for (int s = 0; s < MOD_STEP; s++) begin
			t = {rem_nxt, sh_q[RND_W-1-s]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_nxt = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CW'(MOD_CNT_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << MOD_STEP;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> hw/rtl/sfy_buf.sv
// Item buffer: one write port, two registered read ports.
module sfy_buf #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    ra_addr,
	input  logic [AW-1:0]    rb_addr,
	output logic [WIDTH-1:0] ra_data,
	output logic [WIDTH-1:0] rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			ra_data <= mem[ra_addr];
			rb_data <= mem[rb_addr];
		end
	end

endmodule

>>> hw/rtl/seeded_fisher_yates_shuffle_top.sv
// Top level of the seeded shuffle block: load, shuffle and readout control.
//
//  channel | signals                                        | beat
//  --------+------------------------------------------------+----------------------------
//  cfg     | cfg_valid cfg_ready cfg_data                   | new 64-bit seed
//  in      | in_valid in_ready item_word final_item         | one list element
//  out     | out_valid out_ready shuffled_word position     | one shuffled element
//          | final_result overflowed                        |
//
//  Load: one input beat per cycle. Each shuffle swap runs the generator (two 16-digit
//  serial multiplies), then the remainder unit (32 steps of two bits), then a read and
//  two writes for the swap through the single write port of the buffer.
//  Readout: each output beat is read from the buffer, registered, then held until taken.
//  Reset clears control state and the seed; buffer contents stay undefined.
//  in_ready is low from the final beat until the last output beat is taken.
module seeded_fisher_yates_shuffle_top #(
	parameter int MAX_ITEMS  = 64,
	parameter int ITEM_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sfy_pkg::RND_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ITEM_WIDTH-1:0]     item_word,
	input  logic                      final_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ITEM_WIDTH-1:0]     shuffled_word,
	output logic [sfy_pkg::POS_W-1:0] position,
	output logic                      final_result,
	output logic                      overflowed
);
	import sfy_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [9:0] {
		S_LOAD  = 10'b0000000001,
		S_CHECK = 10'b0000000010,
		S_GEN   = 10'b0000000100,
		S_MOD   = 10'b0000001000,
		S_SWR   = 10'b0000010000,
		S_SW1   = 10'b0000100000,
		S_SW2   = 10'b0001000000,
		S_RD    = 10'b0010000000,
		S_RDW   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t            st_q;
	logic [RND_W-1:0]  seed_q;
	logic [CW-1:0]     count_q;
	logic              drop_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     k_q;
	logic [AW-1:0]     j_q;
	logic              out_valid_q;
	logic [ITEM_WIDTH-1:0] word_q;
	logic [POS_W-1:0]  pos_q;
	logic              fin_q;
	logic              ovf_q;

	logic              in_acc;
	logic              has_room;
	logic [CW-1:0]     count_nxt;
	logic              last_k;
	gen_ctl_t          gen_ctl;
	logic              gen_done;
	logic [RND_W-1:0]  gen_rnd;
	logic              mod_start;
	logic              mod_done;
	logic [CW-1:0]     mod_rem;
	logic              buf_we;
	logic [AW-1:0]     buf_waddr;
	logic [ITEM_WIDTH-1:0] buf_wdata;
	logic              buf_re;
	logic [AW-1:0]     buf_ra;
	logic [AW-1:0]     buf_rb;
	logic [ITEM_WIDTH-1:0] ra_data;
	logic [ITEM_WIDTH-1:0] rb_data;
	logic [AW-1:0]     top_addr;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign has_room  = (count_q < CW'(MAX_ITEMS));
	assign count_nxt = has_room ? CW'(count_q + 1'b1) : count_q;
	assign last_k    = (CW'(k_q + 1'b1) == count_q);
	assign top_addr  = AW'(i_q - 1'b1);

	assign gen_ctl.seed_load = in_acc && final_item;
	assign gen_ctl.start     = (st_q == S_CHECK) && (i_q > CW'(1));
	assign mod_start         = (st_q == S_GEN) && gen_done;

	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = count_q[AW-1:0];
		buf_wdata = item_word;
		buf_re    = 1'b0;
		buf_ra    = top_addr;
		buf_rb    = j_q;
		unique case (st_q)
			S_LOAD: begin
				buf_we = in_acc && has_room;
			end
			S_SWR: begin
				buf_re = 1'b1;
			end
			S_SW1: begin
				buf_we    = 1'b1;
				buf_waddr = top_addr;
				buf_wdata = rb_data;
			end
			S_SW2: begin
				buf_we    = 1'b1;
				buf_waddr = j_q;
				buf_wdata = ra_data;
			end
			S_RD: begin
				buf_re = 1'b1;
				buf_ra = k_q[AW-1:0];
			end
			default: begin
				buf_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_LOAD;
			seed_q      <= '0;
			count_q     <= '0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			unique case (st_q)
				S_LOAD: begin
					if (in_acc) begin
						count_q <= count_nxt;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (final_item) begin
							i_q  <= count_nxt;
							st_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (i_q > CW'(1)) begin
						st_q <= S_GEN;
					end else begin
						k_q  <= '0;
						st_q <= S_RD;
					end
				end
				S_GEN: begin
					if (gen_done) begin
						st_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						st_q <= S_SWR;
					end
				end
				S_SWR: begin
					st_q <= S_SW1;
				end
				S_SW1: begin
					st_q <= S_SW2;
				end
				S_SW2: begin
					i_q  <= i_q - 1'b1;
					st_q <= S_CHECK;
				end
				S_RD: begin
					st_q <= S_RDW;
				end
				S_RDW: begin
					out_valid_q <= 1'b1;
					st_q        <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (fin_q) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							st_q    <= S_LOAD;
						end else begin
							k_q  <= k_q + 1'b1;
							st_q <= S_RD;
						end
					end
				end
				default: begin
					st_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_MOD && mod_done) begin
			j_q <= mod_rem[AW-1:0];
		end
		if (st_q == S_RDW) begin
			word_q <= ra_data;
			pos_q  <= POS_W'(k_q);
			fin_q  <= last_k;
			ovf_q  <= last_k && drop_q;
		end
	end

	sfy_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gen_ctl),
		.seed   (seed_q),
		.done   (gen_done),
		.rnd    (gen_rnd)
	);

	sfy_mod #(
		.DW (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (gen_rnd),
		.divisor  (i_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	sfy_buf #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (ITEM_WIDTH),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.we      (buf_we),
		.waddr   (buf_waddr),
		.wdata   (buf_wdata),
		.re      (buf_re),
		.ra_addr (buf_ra),
		.rb_addr (buf_rb),
		.ra_data (ra_data),
		.rb_data (rb_data)
	);

	assign out_valid     = out_valid_q;
	assign shuffled_word = word_q;
	assign position      = pos_q;
	assign final_result  = fin_q;
	assign overflowed    = ovf_q;

endmodule

>>> dv/tb_seeded_fisher_yates_shuffle_top.sv
// Self-checking testbench for the seeded shuffle block: lists in, shuffled beats checked.
module tb_seeded_fisher_yates_shuffle_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W     = 16;
	localparam int SLOTS      = 64;
	localparam int RANDOM_N   = 500;
	localparam int CALM_AFTER = 440;
	localparam int SETTLE     = 12;
	localparam int STUCK_MAX  = 20000;

	typedef struct {
		logic [WORD_W-1:0]         word;
		logic [sfy_pkg::POS_W-1:0] pos;
		logic                      last;
		logic                      ovf;
	} beat_t;

	class shuffle_tracker;
		logic [WORD_W-1:0] held_words[SLOTS];
		int unsigned       held;
		bit                spilled;
		logic [63:0]       seed;
		logic [63:0]       mix_state;
		beat_t             due_beats[$];
		int                errors;
		int                beats_ok;
		int                lists;
		int                spill_lists;

		function new();
			held        = 0;
			spilled     = 0;
			seed        = '0;
			mix_state   = '0;
			errors      = 0;
			beats_ok    = 0;
			lists       = 0;
			spill_lists = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR %0t: %s", $realtime, msg);
		endfunction

		function void set_seed(logic [63:0] v);
			seed = v;
		endfunction

		function logic [63:0] mix_next();
			logic [63:0] v;
			mix_state = mix_state + sfy_pkg::GOLDEN;
			v = mix_state;
			v = (v ^ (v >> sfy_pkg::SHR1)) * sfy_pkg::MIX1;
			v = (v ^ (v >> sfy_pkg::SHR2)) * sfy_pkg::MIX2;
			return v ^ (v >> sfy_pkg::SHR3);
		endfunction

		function void load_item(logic [WORD_W-1:0] w, logic fin);
			int unsigned       i;
			int unsigned       j;
			logic [63:0]       r;
			logic [WORD_W-1:0] t;
			beat_t             b;
			if (held < SLOTS) begin
				held_words[held] = w;
				held++;
			end else begin
				spilled = 1'b1;
			end
			if (!fin)
				return;
			mix_state = seed ^ sfy_pkg::SALT;
			for (i = held; i > 1; i--) begin
				r = mix_next() % 64'(i);
				j = int'(r);
				t = held_words[i-1];
				held_words[i-1] = held_words[j];
				held_words[j] = t;
			end
			for (i = 0; i < held; i++) begin
				b.word = held_words[i];
				b.pos  = i[sfy_pkg::POS_W-1:0];
				b.last = (i + 1 == held);
				b.ovf  = b.last && spilled;
				due_beats.push_back(b);
			end
			lists++;
			if (spilled)
				spill_lists++;
			held    = 0;
			spilled = 0;
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (due_beats.size() == 0) begin
				flag($sformatf("unexpected beat: word %h pos %0d last %b ovf %b",
					got.word, got.pos, got.last, got.ovf));
				return;
			end
			want = due_beats.pop_front();
			if (got.word !== want.word || got.pos !== want.pos ||
					got.last !== want.last || got.ovf !== want.ovf)
				flag($sformatf("beat mismatch: want word %h pos %0d last %b ovf %b, got word %h pos %0d last %b ovf %b",
					want.word, want.pos, want.last, want.ovf,
					got.word, got.pos, got.last, got.ovf));
			else
				beats_ok++;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [sfy_pkg::RND_W-1:0] cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [WORD_W-1:0]         item_word;
	logic                      final_item;
	logic                      out_valid;
	logic                      out_ready;
	logic [WORD_W-1:0]         shuffled_word;
	logic [sfy_pkg::POS_W-1:0] position;
	logic                      final_result;
	logic                      overflowed;

	shuffle_tracker tracker = new();
	bit             calm;
	bit             running;
	int             items_sent;
	int             seeds_written;
	int             stuck_cycles;
	int             stall_left;

	seeded_fisher_yates_shuffle_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.item_word    (item_word),
		.final_item   (final_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.shuffled_word(shuffled_word),
		.position     (position),
		.final_result (final_result),
		.overflowed   (overflowed)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		beat_t got;
		bit    moved;
		moved = 1'b0;
		if (running) begin
			if (cfg_valid && cfg_ready) begin
				tracker.set_seed(cfg_data);
				moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				tracker.load_item(item_word, final_item);
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				got.word = shuffled_word;
				got.pos  = position;
				got.last = final_result;
				got.ovf  = overflowed;
				tracker.check_beat(got);
				moved = 1'b1;
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_MAX) begin
				$display("timeout: no beat for %0d cycles", STUCK_MAX);
				$display("tb_seeded_fisher_yates_shuffle_top: done, errors");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [WORD_W-1:0] w, input logic fin);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		item_word  <= w;
		final_item <= fin;
		items_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic push_list(input int len);
		for (int k = 0; k < len; k++)
			push_item(WORD_W'($urandom_range(0, 65535)), k == len - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_seed(input logic [63:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		seeds_written++;
	endtask

	initial begin
		int list_no;
		int len;
		int pick;
		int random_start;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		item_word     = '0;
		final_item    = 1'b0;
		out_ready     = 1'b0;
		calm          = 1'b0;
		running       = 1'b0;
		items_sent    = 0;
		seeds_written = 0;
		stuck_cycles  = 0;
		stall_left    = 0;
		repeat (10) @(negedge clk);
		arst_n  = 1'b1;
		running = 1'b1;

		// single entry, two entries, and word extremes under the reset seed
		push_item(16'hFFFF, 1'b1);
		push_item(16'h0000, 1'b0);
		push_item(16'hFFFF, 1'b1);
		push_item(16'h0001, 1'b0);
		push_item(16'h8000, 1'b0);
		push_item(16'h7FFF, 1'b1);
		drain();
		// seed equal to the salt starts the generator from zero
		write_seed(sfy_pkg::SALT);
		for (int k = 0; k < 8; k++)
			push_item(WORD_W'(k), k == 7);
		drain();
		write_seed('1);
		push_list(5);
		drain();

		random_start = items_sent;
		list_no = 0;
		while (items_sent - random_start < RANDOM_N) begin
			pick = $urandom_range(0, 5);
			case (pick)
				0: write_seed('0);
				1: write_seed('1);
				default: write_seed({$urandom, $urandom});
			endcase
			repeat ($urandom_range(1, 4)) begin
				if (items_sent - random_start >= CALM_AFTER)
					calm = 1'b1;
				pick = $urandom_range(0, 19);
				if (list_no == 1 || pick == 0)
					len = SLOTS;
				else if (list_no == 3 || pick == 1)
					len = $urandom_range(SLOTS + 1, SLOTS + 8);
				else
					len = $urandom_range(1, 16);
				push_list(len);
				list_no++;
			end
			drain();
		end

		if (tracker.pending() != 0)
			tracker.flag($sformatf("%0d beats never arrived", tracker.pending()));
		$display("covered %0d lists (%0d past capacity) from %0d items, %0d beats matched",
			tracker.lists, tracker.spill_lists, items_sent, tracker.beats_ok);
		$display("seed writes: %0d, mismatches: %0d", seeds_written, tracker.errors);
		if (tracker.errors == 0)
			$display("tb_seeded_fisher_yates_shuffle_top: done, clean");
		else
			$display("tb_seeded_fisher_yates_shuffle_top: done, errors");
		$finish;
	end

endmodule
